// ===== design/ccwn_pkg.sv =====
// Shared widths, register indexes and limits for the color channel weighted normalizer.
package ccwn_pkg;

	localparam int WEIGHT_BITS   = 24;
	localparam int INTEG_BITS    = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int LEVEL_BITS    = 32;
	localparam int FULL_BITS     = 16;
	localparam int DIV_BITS      = FULL_BITS + 1;

	localparam logic [INTEG_BITS-1:0]    INTEG_RESET    = 8'hF6;
	localparam logic [WEIGHT_BITS-1:0]   W_CLEAR_RESET  = 24'h01_0000;
	localparam logic [WEIGHT_BITS-1:0]   W_OTHER_RESET  = 24'h00_0000;
	localparam logic [INTEG_BITS:0]      FULL_BASE      = 9'd256;
	localparam int                       FULL_STEP_SH   = 10;
	localparam logic [FULL_BITS-1:0]     FULL_CAP       = 16'hFFFF;

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 32'h7FFF_FFFF;
	localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 32'h8000_0000;
	localparam logic [LEVEL_BITS:0]   LIM_POS   = 33'h0_7FFF_FFFF;
	localparam logic [LEVEL_BITS:0]   LIM_NEG   = 33'h0_8000_0000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_INTEG   = 3'd0,
		REG_W_CLEAR = 3'd1,
		REG_W_RED   = 3'd2,
		REG_W_GREEN = 3'd3,
		REG_W_BLUE  = 3'd4
	} ccwn_reg_t;

endpackage

// ===== design/color_channel_weighted_normalizer.sv =====
// Top level: pipelined weighted sum of four color counts, divided by full scale.
//
//  channel    direction  signals                                          request moves on
//  ---------  ---------  -----------------------------------------------  -------------------
//  input      in         start, busy, clear/red/green/blue_count          start & !busy
//  result     out        done, weighted_level, saturated                  done (one cycle)
//  config     in         cfg_we, cfg_index, cfg_wdata                     cfg_we
//
// A request enters every cycle; busy is held low since nothing downstream can
// push back. Each request passes through seven fixed stages plus one
// restoring-divider step per quotient bit, COUNT_BITS + 16 of them. The divider
// chain sets the latency.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Write configuration only while no request is in flight.
module color_channel_weighted_normalizer #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [COUNT_BITS-1:0]                  clear_count,
	input  logic [COUNT_BITS-1:0]                  red_count,
	input  logic [COUNT_BITS-1:0]                  green_count,
	input  logic [COUNT_BITS-1:0]                  blue_count,
	input  logic                                   cfg_we,
	input  logic [ccwn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [ccwn_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	output logic                                   done,
	output logic signed [ccwn_pkg::LEVEL_BITS-1:0] weighted_level,
	output logic                                   saturated
);
	import ccwn_pkg::*;

	// Widths of the datapath, most following the count width.
	localparam int PW   = COUNT_BITS + 25;   // one product
	localparam int P2W  = COUNT_BITS + 26;   // sum of two products
	localparam int SW   = COUNT_BITS + 27;   // sum of four products
	localparam int TW   = COUNT_BITS + 28;   // 2*sum + full, signed
	localparam int MW   = COUNT_BITS + 27;   // magnitude of the dividend
	localparam int NQ   = COUNT_BITS + 16;   // quotient bits (divisor is at least 2^11)
	localparam int DW   = DIV_BITS;          // divisor and remainder
	localparam int EW   = (NQ + 1 > LEVEL_BITS + 1) ? NQ + 1 : LEVEL_BITS + 1;

	// Configuration registers.
	logic [INTEG_BITS-1:0]         integ_q;
	logic signed [WEIGHT_BITS-1:0] w_clear_q;
	logic signed [WEIGHT_BITS-1:0] w_red_q;
	logic signed [WEIGHT_BITS-1:0] w_green_q;
	logic signed [WEIGHT_BITS-1:0] w_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= INTEG_RESET;
			w_clear_q <= signed'(W_CLEAR_RESET);
			w_red_q   <= signed'(W_OTHER_RESET);
			w_green_q <= signed'(W_OTHER_RESET);
			w_blue_q  <= signed'(W_OTHER_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTEG:   integ_q   <= cfg_wdata[INTEG_BITS-1:0];
				REG_W_CLEAR: w_clear_q <= signed'(cfg_wdata[WEIGHT_BITS-1:0]);
				REG_W_RED:   w_red_q   <= signed'(cfg_wdata[WEIGHT_BITS-1:0]);
				REG_W_GREEN: w_green_q <= signed'(cfg_wdata[WEIGHT_BITS-1:0]);
				REG_W_BLUE:  w_blue_q  <= signed'(cfg_wdata[WEIGHT_BITS-1:0]);
				default: ;  // unused index: drop the write
			endcase
		end
	end

	// Full scale: (256 - setting) * 1024, capped to 16 bits. Divisor is twice that.
	logic [INTEG_BITS:0]                  fs_diff;
	logic [INTEG_BITS+FULL_STEP_SH:0]     fs_raw;
	logic [FULL_BITS-1:0]                 full;
	logic [DW-1:0]                        divisor;

	always_comb begin
		fs_diff = FULL_BASE - {1'b0, integ_q};
		fs_raw  = {fs_diff, {FULL_STEP_SH{1'b0}}};
		if (fs_raw > (INTEG_BITS + FULL_STEP_SH + 1)'(FULL_CAP))
			full = FULL_CAP;
		else
			full = fs_raw[FULL_BITS-1:0];
		divisor = {full, 1'b0};
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	// ---------------------------------------------------------------- s1: products
	logic                 valid_s1;
	logic signed [PW-1:0] prod_c_s1, prod_r_s1, prod_g_s1, prod_b_s1;

	always_ff @(posedge clk) begin
		prod_c_s1 <= signed'({1'b0, clear_count}) * w_clear_q;
		prod_r_s1 <= signed'({1'b0, red_count})   * w_red_q;
		prod_g_s1 <= signed'({1'b0, green_count}) * w_green_q;
		prod_b_s1 <= signed'({1'b0, blue_count})  * w_blue_q;
	end

	// ---------------------------------------------------------------- s2: pair sums
	logic                  valid_s2;
	logic signed [P2W-1:0] pair_a_s2, pair_b_s2;

	always_ff @(posedge clk) begin
		pair_a_s2 <= P2W'(prod_c_s1) + P2W'(prod_r_s1);
		pair_b_s2 <= P2W'(prod_g_s1) + P2W'(prod_b_s1);
	end

	// ---------------------------------------------------------------- s3: full sum
	logic                 valid_s3;
	logic signed [SW-1:0] sum_s3;

	always_ff @(posedge clk) begin
		sum_s3 <= SW'(pair_a_s2) + SW'(pair_b_s2);
	end

	// ---------------------------------------------------------------- s4: rounding bias
	// t = 2*sum + full, so floor(t / 2*full) rounds to nearest, ties up.
	logic                 valid_s4;
	logic signed [TW-1:0] t_s4;
	logic signed [TW-1:0] full_ext;

	assign full_ext = signed'(TW'(full));

	always_ff @(posedge clk) begin
		t_s4 <= (TW'(sum_s3) <<< 1) + full_ext;
	end

	// ---------------------------------------------------------------- s5: sign and magnitude
	logic          valid_s5;
	logic          neg_s5;
	logic [MW-1:0] mag_s5;
	logic [TW-1:0] t_neg;

	assign t_neg = TW'(-t_s4);

	always_ff @(posedge clk) begin
		neg_s5 <= t_s4[TW-1];
		mag_s5 <= t_s4[TW-1] ? t_neg[MW-1:0] : t_s4[MW-1:0];
	end

	// ---------------------------------------------------------------- s6: restoring divider
	// One quotient bit per step. The dividend's low bits shift out of dq at the top
	// while quotient bits shift in at the bottom. Top MW-NQ bits start as remainder;
	// they are below 2^11, which never exceeds the divisor.
	logic [NQ-1:0] div_vld_s6;
	logic [DW-1:0] div_rem_s6 [NQ];
	logic [NQ-1:0] div_dq_s6  [NQ];
	logic          div_neg_s6 [NQ];

	for (genvar j = 0; j < NQ; j++) begin : g_div
		logic          vld_in;
		logic [DW-1:0] rem_in;
		logic [NQ-1:0] dq_in;
		logic          neg_in;
		logic [DW:0]   trial;
		logic          take;

		if (j == 0) begin : g_head
			assign vld_in = valid_s5;
			assign rem_in = DW'(mag_s5[MW-1:NQ]);
			assign dq_in  = mag_s5[NQ-1:0];
			assign neg_in = neg_s5;
		end else begin : g_body
			assign vld_in = div_vld_s6[j-1];
			assign rem_in = div_rem_s6[j-1];
			assign dq_in  = div_dq_s6[j-1];
			assign neg_in = div_neg_s6[j-1];
		end

		assign trial = {rem_in, dq_in[NQ-1]};
		assign take  = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s6[j] <= 1'b0;
			end else begin
				div_vld_s6[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			div_rem_s6[j] <= take ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
			div_dq_s6[j]  <= {dq_in[NQ-2:0], take};
			div_neg_s6[j] <= neg_in;
		end
	end

	// ---------------------------------------------------------------- s7: floor fix-up
	// Negative dividend: floor means one more in magnitude when a remainder is left.
	logic          valid_s7;
	logic          neg_s7;
	logic [NQ:0]   qmag_s7;

	always_ff @(posedge clk) begin
		neg_s7  <= div_neg_s6[NQ-1];
		qmag_s7 <= (NQ + 1)'(div_dq_s6[NQ-1])
			+ (NQ + 1)'(div_neg_s6[NQ-1] && (div_rem_s6[NQ-1] != '0));
	end

	// ---------------------------------------------------------------- s8: sign and clamp
	logic                  valid_s8;
	logic [LEVEL_BITS-1:0] level_s8;
	logic                  sat_s8;
	logic [EW-1:0]         qe;
	logic [EW-1:0]         qe_neg;
	logic [LEVEL_BITS-1:0] level_nx;
	logic                  sat_nx;

	always_comb begin
		qe     = EW'(qmag_s7);
		qe_neg = EW'(0) - qe;
		if (neg_s7) begin
			sat_nx   = qe > EW'(LIM_NEG);
			level_nx = sat_nx ? LEVEL_MIN : qe_neg[LEVEL_BITS-1:0];
		end else begin
			sat_nx   = qe > EW'(LIM_POS);
			level_nx = sat_nx ? LEVEL_MAX : qe[LEVEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		level_s8 <= level_nx;
		sat_s8   <= sat_nx;
	end

	// Valid bits for the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s7 <= div_vld_s6[NQ-1];
			valid_s8 <= valid_s7;
		end
	end

	assign done           = valid_s8;
	assign weighted_level = signed'(level_s8);
	assign saturated      = sat_s8;

endmodule

// ===== design/ccwn_chk.sv =====
// Port-level checker for the normalizer, with its bind.
module ccwn_chk #(
	parameter int COUNT_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic signed [ccwn_pkg::LEVEL_BITS-1:0] weighted_level,
	input logic                                   saturated
);
	import ccwn_pkg::*;

	localparam int LAT = COUNT_BITS + 23;

	// Every taken request is followed by a result.
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LAT) done)
		else $error("request taken but no result after fixed latency");

	// No result without a matching taken request.
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	// A clamped result sits at one of the range limits.
	a_sat_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(weighted_level == signed'(LEVEL_MAX) || weighted_level == signed'(LEVEL_MIN)))
		else $error("saturated result not at a range limit");

endmodule

bind color_channel_weighted_normalizer ccwn_chk #(.COUNT_BITS(COUNT_BITS)) u_ccwn_chk (.*);
